// ===== rtl/swfs_pkg.sv =====
package swfs_pkg;

    localparam int FRAME_BYTES  = 11;
    localparam int BYTE_W       = 8;
    localparam int BYTE_INDEX_W = 6;
    localparam int IDX_W        = $clog2(FRAME_BYTES);
    localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_SECOND   = 3'd3;

    localparam logic [BYTE_W-1:0] RST_START_FIRST  = 8'h5A;
    localparam logic [BYTE_W-1:0] RST_START_SECOND = 8'hA5;
    localparam logic [BYTE_W-1:0] RST_END_FIRST    = 8'h0D;
    localparam logic [BYTE_W-1:0] RST_END_SECOND   = 8'h0A;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } frame_push_t;

    typedef struct packed {
        logic   not_empty;
        logic   full;
        frame_t head;
    } queue_status_t;

endpackage

// ===== rtl/swfs_stream_if.sv =====
interface swfs_in_if;
    import swfs_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface swfs_out_if;
    import swfs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BYTE_W-1:0]       frame_byte;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic                    last_flag;

    modport source (output valid, output frame_byte, output byte_index,
                    output last_flag, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last_flag, output ready);
endinterface

// ===== rtl/swfs_front.sv =====
module swfs_front
    import swfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    swfs_in_if.sink               in_ch,
    input  queue_status_t         q_status,
    output frame_push_t           push
);

    logic [BYTE_W-1:0] start_first_reg;
    logic [BYTE_W-1:0] start_second_reg;
    logic [BYTE_W-1:0] end_first_reg;
    logic [BYTE_W-1:0] end_second_reg;

    frame_t            window_reg;
    frame_t            window_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              accept;
    logic              markers_ok;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[FRAME_BYTES-1] = in_ch.rx_byte;
    end

    always_comb
    begin
        if (in_ch.mode == MODE_CLEAR)
        begin
            fill_next = '0;
        end
        else if (fill_reg != CNT_W'(FRAME_BYTES))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    assign markers_ok = (window_next[0] == start_first_reg) &&
                        (window_next[1] == start_second_reg) &&
                        (window_next[FRAME_BYTES-2] == end_first_reg) &&
                        (window_next[FRAME_BYTES-1] == end_second_reg);

    assign push.valid = accept && (in_ch.mode == MODE_PUSH) &&
                        (fill_next == CNT_W'(FRAME_BYTES)) && markers_ok;
    assign push.frame = window_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.mode == MODE_PUSH))
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= RST_START_FIRST;
            start_second_reg <= RST_START_SECOND;
            end_first_reg    <= RST_END_FIRST;
            end_second_reg   <= RST_END_SECOND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_FIRST:  start_first_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_START_SECOND: start_second_reg <= cfg_wdata[BYTE_W-1:0];
                REG_END_FIRST:    end_first_reg    <= cfg_wdata[BYTE_W-1:0];
                REG_END_SECOND:   end_second_reg   <= cfg_wdata[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

// ===== rtl/swfs_queue.sv =====
module swfs_queue
    import swfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frame_push_t   push,
    input  logic          pop,
    output queue_status_t status
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push.valid && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    assign status.not_empty = (count_reg != 2'd0);
    assign status.full      = (count_reg == 2'd2);
    assign status.head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.frame;
        end
    end

endmodule

// ===== rtl/swfs_back.sv =====
module swfs_back
    import swfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    output logic          pop,
    swfs_out_if.source    out_ch
);

    logic             busy_reg;
    frame_t           shift_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_acc;
    logic             is_last;

    assign is_last = (idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign out_acc = busy_reg && out_ch.ready;
    assign pop     = q_status.not_empty && (!busy_reg || (out_acc && is_last));

    assign out_ch.valid      = busy_reg;
    assign out_ch.frame_byte = shift_reg[0];
    assign out_ch.byte_index = BYTE_INDEX_W'(idx_reg);
    assign out_ch.last_flag  = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_acc)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg <= q_status.head;
        end
        else if (out_acc && !is_last)
        begin
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                shift_reg[i] <= shift_reg[i+1];
            end
        end
    end

endmodule

// ===== rtl/sliding_window_frame_sync_top.sv =====
// A matched frame goes to a queue entry, then to the serializer shift register.
// Throughput: one byte per cycle while the two-frame queue has room; the serializer
// then sends one result per cycle while ready is high, FRAME_BYTES per frame.
// Reset: asynchronous, active low; window emptied, queue empty, markers at
// their default values.
module sliding_window_frame_sync_top
    import swfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    swfs_in_if.sink               in_ch,
    swfs_out_if.source            out_ch
);

    frame_push_t   push;
    queue_status_t q_status;
    logic          pop;

    swfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_status  (q_status),
        .push      (push)
    );

    swfs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (q_status)
    );

    swfs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// ===== rtl/swfs_checker.sv =====
module swfs_checker
    import swfs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [BYTE_W-1:0]       frame_byte,
    input logic [BYTE_INDEX_W-1:0] byte_index,
    input logic                    last_flag
);

    localparam logic [BYTE_INDEX_W-1:0] LAST_INDEX = BYTE_INDEX_W'(FRAME_BYTES - 1);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
        $stable(byte_index) && $stable(last_flag))
        else $error("result item changed while stalled");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_flag == (byte_index == LAST_INDEX)))
        else $error("last flag does not match final byte position");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_flag |=>
        out_valid && (byte_index == $past(byte_index) + BYTE_INDEX_W'(1)))
        else $error("frame bytes not sent in consecutive order");

endmodule

bind sliding_window_frame_sync_top swfs_checker u_swfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .frame_byte (out_ch.frame_byte),
    .byte_index (out_ch.byte_index),
    .last_flag  (out_ch.last_flag)
);

// ===== bench/tb.sv =====
module tb;
    import swfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 3'd7;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_kind_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]       frame_byte;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic                    last_flag;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    swfs_in_if  in_ch ();
    swfs_out_if out_ch ();

    sliding_window_frame_sync_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    rx_item_t      pending_items [$];
    frame_result_t frame_expect [$];

    int queued_total;
    int accepted_total;
    int fail_count;
    int cycle_count;
    bit hold_request;

    logic [BYTE_W-1:0] mk_start_first;
    logic [BYTE_W-1:0] mk_start_second;
    logic [BYTE_W-1:0] mk_end_first;
    logic [BYTE_W-1:0] mk_end_second;
    logic [BYTE_W-1:0] window_copy [FRAME_BYTES];
    int                fill_pos;
    logic              window_filled;

    int burst_left;
    int gap_left;

    int          seg_left;
    int          seg_phase;
    ready_kind_t seg_kind;
    int          long_hold_left;
    bit          long_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic clear_window_copy();
        for (int k = 0; k < FRAME_BYTES; k++)
            window_copy[k] = '0;
        fill_pos      = 0;
        window_filled = 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] window_from_oldest(input int offset);
        return window_copy[(fill_pos + offset) % FRAME_BYTES];
    endfunction

    task automatic track_rx_item(input logic mode, input logic [BYTE_W-1:0] rx_byte);
        frame_result_t r;
        if (mode == MODE_CLEAR)
        begin
            clear_window_copy();
            return;
        end
        window_copy[fill_pos] = rx_byte;
        fill_pos = (fill_pos + 1) % FRAME_BYTES;
        if (!window_filled)
        begin
            if (fill_pos == 0)
                window_filled = 1'b1;
            else
                return;
        end
        if (window_from_oldest(0) != mk_start_first ||
            window_from_oldest(1) != mk_start_second ||
            window_from_oldest(FRAME_BYTES - 2) != mk_end_first ||
            window_from_oldest(FRAME_BYTES - 1) != mk_end_second)
            return;
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            r.frame_byte = window_from_oldest(k);
            r.byte_index = k[BYTE_INDEX_W-1:0];
            r.last_flag  = (k == FRAME_BYTES - 1);
            frame_expect.push_back(r);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive
        rx_item_t next_item;
        logic     next_valid;
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.mode    <= MODE_PUSH;
            in_ch.rx_byte <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_rx_item(in_ch.mode, in_ch.rx_byte);
                accepted_total++;
            end
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                next_item  = pending_items.pop_front();
                next_valid = 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 30);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                in_ch.mode    <= next_item.mode;
                in_ch.rx_byte <= next_item.rx_byte;
            end
            in_ch.valid <= next_valid;
        end
    end

    // receiver: own stall pattern, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_result_t want;
        logic          next_ready;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            seg_left       = 0;
            seg_phase      = 0;
            seg_kind       = READY_ALWAYS;
            long_hold_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (frame_expect.size() == 0)
                begin
                    $error("frame_byte %0h index %0d arrived with nothing pending",
                           out_ch.frame_byte, out_ch.byte_index);
                    fail_count++;
                end
                else
                begin
                    want = frame_expect.pop_front();
                    if (out_ch.frame_byte !== want.frame_byte)
                    begin
                        $error("frame_byte: expected %0h, got %0h",
                               want.frame_byte, out_ch.frame_byte);
                        fail_count++;
                    end
                    if (out_ch.byte_index !== want.byte_index)
                    begin
                        $error("byte_index: expected %0d, got %0d",
                               want.byte_index, out_ch.byte_index);
                        fail_count++;
                    end
                    if (out_ch.last_flag !== want.last_flag)
                    begin
                        $error("last_flag: expected %0b, got %0b",
                               want.last_flag, out_ch.last_flag);
                        fail_count++;
                    end
                end
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                next_ready = 1'b0;
            end
            else if (hold_request && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD;
                next_ready     = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left  = $urandom_range(4, 60);
                    seg_phase = 0;
                    case ($urandom_range(0, 2))
                        0:       seg_kind = READY_ALWAYS;
                        1:       seg_kind = READY_RANDOM;
                        default: seg_kind = READY_SPARSE;
                    endcase
                end
                seg_left--;
                seg_phase++;
                case (seg_kind)
                    READY_ALWAYS: next_ready = 1'b1;
                    READY_RANDOM: next_ready = 1'($urandom_range(0, 1));
                    default:      next_ready = (seg_phase % 4 == 0);
                endcase
            end
            out_ch.ready <= next_ready;
        end
    end

    function automatic void add_push(input logic [BYTE_W-1:0] value);
        pending_items.push_back('{mode: MODE_PUSH, rx_byte: value});
        queued_total++;
    endfunction

    function automatic void add_clear(input logic [BYTE_W-1:0] value);
        pending_items.push_back('{mode: MODE_CLEAR, rx_byte: value});
        queued_total++;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return mk_start_first;
            1:       return mk_start_second;
            2:       return mk_end_first;
            3:       return mk_end_second;
            default: return rand_byte();
        endcase
    endfunction

    function automatic void add_frame(input int body_len, input bit with_trailer);
        add_push(mk_start_first);
        add_push(mk_start_second);
        for (int k = 0; k < body_len; k++)
            add_push(rand_byte());
        if (with_trailer)
        begin
            add_push(mk_end_first);
            add_push(mk_end_second);
        end
    endfunction

    function automatic void add_random_traffic(input int n_items);
        int target;
        int pick;
        int run;
        target = queued_total + n_items;
        while (queued_total < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                add_frame(FRAME_BYTES - 4, 1'b1);
            else if (pick < 14)
                add_frame($urandom_range(0, FRAME_BYTES - 3), 1'b0);
            else if (pick < 18)
            begin
                run = $urandom_range(1, 4);
                for (int k = 0; k < run; k++)
                    add_push(noise_byte());
            end
            else
                add_clear(rand_byte());
        end
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_FIRST:  mk_start_first  = value;
            REG_START_SECOND: mk_start_second = value;
            REG_END_FIRST:    mk_end_first    = value;
            REG_END_SECOND:   mk_end_second   = value;
            default:          ;
        endcase
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
                               input logic [BYTE_W-1:0] ef, input logic [BYTE_W-1:0] es);
        cfg_write(REG_START_FIRST, sf);
        cfg_write(REG_START_SECOND, ss);
        cfg_write(REG_END_FIRST, ef);
        cfg_write(REG_END_SECOND, es);
    endtask

    task automatic settle();
        while (!(accepted_total == queued_total && frame_expect.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_PUSH;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        queued_total   = 0;
        accepted_total = 0;
        fail_count     = 0;
        cycle_count    = 0;
        hold_request   = 1'b0;
        mk_start_first  = RST_START_FIRST;
        mk_start_second = RST_START_SECOND;
        mk_end_first    = RST_END_FIRST;
        mk_end_second   = RST_END_SECOND;
        clear_window_copy();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default markers: frame completing the first fill, then clear and a partial refill
        add_push(RST_START_FIRST);
        add_push(RST_START_SECOND);
        add_push(8'h00);
        add_push(8'hFF);
        add_push(8'h01);
        add_push(8'h80);
        add_push(8'h7F);
        add_push(8'h55);
        add_push(8'hAA);
        add_push(RST_END_FIRST);
        add_push(RST_END_SECOND);
        add_push(8'hFF);
        add_clear(8'hFF);
        add_push(RST_START_FIRST);
        add_push(RST_START_SECOND);
        add_push(RST_END_FIRST);
        add_push(RST_END_SECOND);
        add_clear(8'h00);
        settle();

        // writes to unused indexes, which must leave the markers alone, then random markers
        cfg_write(REG_UNUSED_LOW, 8'h33);
        cfg_write(REG_UNUSED_TOP, 8'hFF);
        set_markers(rand_byte(), rand_byte(), rand_byte(), rand_byte());
        add_random_traffic(30);
        settle();

        // all-zero markers: overlapping frames, receiver held off
        set_markers(8'h00, 8'h00, 8'h00, 8'h00);
        hold_request = 1'b1;
        for (int k = 0; k < FRAME_BYTES + 2; k++)
            add_push(8'h00);
        for (int k = 0; k < 30; k++)
            add_push(($urandom_range(0, 3) == 0) ? rand_byte() : 8'h00);
        settle();

        set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_random_traffic(15);
        settle();

        set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
        add_random_traffic(15);
        settle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swfs_pkg.sv
rtl/swfs_stream_if.sv
rtl/swfs_front.sv
rtl/swfs_queue.sv
rtl/swfs_back.sv
rtl/sliding_window_frame_sync_top.sv
rtl/swfs_checker.sv
bench/tb.sv
